// ===== design/ped_pkg.sv =====
// Shared types, character codes and helper functions for the percent escape decoder.
package ped_pkg;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2,
    PH_SKIP = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_CHAR  = 3'd1,
    ST_BAD_HEX   = 3'd2,
    ST_CUT_SHORT = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_0       = 8'h30;
  localparam logic [7:0] CH_9       = 8'h39;
  localparam logic [7:0] CH_UA      = 8'h41;
  localparam logic [7:0] CH_UF      = 8'h46;
  localparam logic [7:0] CH_UZ      = 8'h5A;
  localparam logic [7:0] CH_LA      = 8'h61;
  localparam logic [7:0] CH_LF      = 8'h66;
  localparam logic [7:0] CH_LZ      = 8'h7A;
  localparam logic [3:0] NIB_TEN    = 4'd10;

  localparam int TDATA_W = 24;
  localparam int TUSER_W = 3;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    logic [7:0] d;
    h = '0;
    d = '0;
    if (c >= CH_0 && c <= CH_9) begin
      d = c - CH_0;
      h.ok = 1'b1;
      h.value = d[3:0];
    end else if (c >= CH_UA && c <= CH_UF) begin
      d = c - CH_UA;
      h.ok = 1'b1;
      h.value = d[3:0] + NIB_TEN;
    end else if (c >= CH_LA && c <= CH_LF) begin
      d = c - CH_LA;
      h.ok = 1'b1;
      h.value = d[3:0] + NIB_TEN;
    end
    return h;
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UZ) ||
           (c >= CH_LA && c <= CH_LZ);
  endfunction

endpackage

// ===== design/percent_escape_decoder.sv =====
// Top level of the percent escape decoder: byte stream in, decoded bytes and status out.
//
// Input stream: one encoded byte per beat on s_tdata, s_tlast marks the last
// byte of a stream. '+' becomes a space, letters and digits pass through,
// '%' plus two hex digits gives one byte. Any other byte ends the stream's
// output with an error beat; the rest of that stream is dropped.
// Output stream: m_tdata carries the decoded byte and the saturated count of
// bytes decoded so far in the stream, m_tuser the status code, m_tlast marks
// the final beat of a stream (end mark or first error).
// '%' and the high digit produce no output beat unless the stream ends on them.
// Each result is registered in the output stage before m_tvalid shows it.
// Throughput: one input beat per cycle while s_tready is high; decode is a single
// pass through the phase logic between the stream state and the output register.
// A two-entry output stage (output register plus skid register) lets the
// input keep flowing for one beat while the receiver stalls; s_tready drops
// only when both entries are full.
// Reset (rst, synchronous) clears the phase, held digit and counter and
// empties the output stage.
module percent_escape_decoder #(
  parameter int COUNT_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,  // [7:0] in_byte
  input  logic                            s_tlast,  // end_of_stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [ped_pkg::TDATA_W-1:0]     m_tdata,  // [7:0] out_byte, [23:8] decoded_count
  output logic [ped_pkg::TUSER_W-1:0]     m_tuser,  // [2:0] status
  output logic                            m_tlast   // stream_done
);
  import ped_pkg::*;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  phase_t                phase, phase_next;
  logic [3:0]            nibble, nibble_next;
  logic                  nibble_bad, nibble_bad_next;
  logic [COUNT_BITS-1:0] byte_counter, byte_counter_next;

  logic                  s_fire;
  hex_t                  hx;
  logic [COUNT_BITS-1:0] cnt_inc;

  logic                  res_valid;
  logic [7:0]            res_byte;
  status_t               res_status;
  logic                  res_done;
  logic                  res_ok;
  logic [COUNT_BITS-1:0] res_cnt;
  logic [15:0]           res_shown;

  logic                  out_valid, skid_valid;
  logic [TDATA_W-1:0]    out_data, skid_data;
  logic [TUSER_W-1:0]    out_user, skid_user;
  logic                  out_last, skid_last;
  logic                  m_fire, load_out, load_skid, pop_skid;

  assign s_tready = !skid_valid;
  assign s_fire   = s_tvalid && s_tready;
  assign hx       = hex_decode(s_tdata);
  assign cnt_inc  = (byte_counter == CNT_MAX) ? byte_counter : byte_counter + 1'b1;

  // result of the current beat
  always_comb begin
    res_valid  = 1'b0;
    res_ok     = 1'b0;
    res_byte   = '0;
    res_status = ST_OK;
    res_done   = s_tlast;
    case (phase)
      PH_IDLE: begin
        res_valid = 1'b1;
        if (s_tdata == CH_PERCENT) begin
          res_valid  = s_tlast;
          res_status = ST_CUT_SHORT;
        end else if (s_tdata == CH_PLUS) begin
          res_ok   = 1'b1;
          res_byte = CH_SPACE;
        end else if (is_alnum(s_tdata)) begin
          res_ok   = 1'b1;
          res_byte = s_tdata;
        end else begin
          res_status = ST_BAD_CHAR;
        end
      end
      PH_HIGH: begin
        res_valid  = s_tlast;
        res_status = ST_CUT_SHORT;
      end
      PH_LOW: begin
        res_valid = 1'b1;
        if (nibble_bad || !hx.ok) begin
          res_status = ST_BAD_HEX;
        end else begin
          res_ok   = 1'b1;
          res_byte = {nibble, hx.value};
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
    if (!res_ok) begin
      res_done = 1'b1;
    end
  end

  assign res_cnt = res_ok ? cnt_inc : byte_counter;

  generate
    if (COUNT_BITS > 16) begin : g_sat
      assign res_shown = (|res_cnt[COUNT_BITS-1:16]) ? 16'hFFFF : res_cnt[15:0];
    end else begin : g_ext
      assign res_shown = 16'(res_cnt);
    end
  endgenerate

  // stream state update
  always_comb begin
    phase_next        = phase;
    nibble_next       = nibble;
    nibble_bad_next   = nibble_bad;
    byte_counter_next = byte_counter;
    case (phase)
      PH_IDLE: begin
        if (s_tdata == CH_PERCENT) begin
          phase_next = PH_HIGH;
        end else if (res_ok) begin
          byte_counter_next = cnt_inc;
        end else begin
          phase_next = PH_SKIP;
        end
      end
      PH_HIGH: begin
        nibble_next     = hx.ok ? hx.value : 4'd0;
        nibble_bad_next = !hx.ok;
        phase_next      = PH_LOW;
      end
      PH_LOW: begin
        if (res_ok) begin
          byte_counter_next = cnt_inc;
          phase_next        = PH_IDLE;
        end else begin
          phase_next = PH_SKIP;
        end
      end
      default: begin
        phase_next = PH_SKIP;
      end
    endcase
    if (s_tlast) begin
      phase_next        = PH_IDLE;
      nibble_next       = '0;
      nibble_bad_next   = 1'b0;
      byte_counter_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      nibble       <= '0;
      nibble_bad   <= 1'b0;
      byte_counter <= '0;
    end else if (s_fire) begin
      phase        <= phase_next;
      nibble       <= nibble_next;
      nibble_bad   <= nibble_bad_next;
      byte_counter <= byte_counter_next;
    end
  end

  // output register with skid entry
  assign m_fire    = out_valid && m_tready;
  assign pop_skid  = m_fire && skid_valid;
  assign load_out  = s_fire && res_valid && (!out_valid || (m_fire && !skid_valid));
  assign load_skid = s_fire && res_valid && out_valid && !m_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (load_out || pop_skid) begin
        out_valid <= 1'b1;
      end else if (m_fire) begin
        out_valid <= 1'b0;
      end
      if (load_skid) begin
        skid_valid <= 1'b1;
      end else if (pop_skid) begin
        skid_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_skid) begin
      out_data <= skid_data;
      out_user <= skid_user;
      out_last <= skid_last;
    end else if (load_out) begin
      out_data <= {res_shown, res_byte};
      out_user <= res_status;
      out_last <= res_done;
    end
    if (load_skid) begin
      skid_data <= {res_shown, res_byte};
      skid_user <= res_status;
      skid_last <= res_done;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tuser  = out_user;
  assign m_tlast  = out_last;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds a beat while output register is empty");

  a_eos_clears: assert property (@(posedge clk) disable iff (rst)
    s_fire && s_tlast |=> phase == PH_IDLE && byte_counter == '0)
    else $error("stream state not cleared after end mark");

  a_error_ends_stream: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_OK |-> m_tlast && m_tdata[7:0] == 8'd0)
    else $error("error beat without stream end or with nonzero byte");

  a_skip_silent: assert property (@(posedge clk) disable iff (rst)
    phase == PH_SKIP |-> !res_valid)
    else $error("skipped byte produced a result");

endmodule
